@@ hdl/fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcr_pkg - framed command receiver shared definitions
// Codes, field widths and the word passed from the frame parser to mode control.
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int NAME_MAX_DEF = 8;
   localparam int PIXEL_COUNT  = 16;
   localparam int LED_COUNT    = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int PIX_LVL_W    = $clog2(PIXEL_COUNT);
   localparam int LED_LVL_W    = $clog2(LED_COUNT);

   typedef logic [1:0] status_type;
   typedef logic [2:0] mode_type;
   typedef logic [2:0] pattern_type;

   localparam logic [7:0] BYTE_START = 8'h02;
   localparam logic [7:0] BYTE_END   = 8'h03;

   localparam status_type STAT_NONE    = 2'd0;
   localparam status_type STAT_OK      = 2'd1;
   localparam status_type STAT_BAD_END = 2'd2;
   localparam status_type STAT_BAD_LEN = 2'd3;

   localparam mode_type MODE_OFF = 3'd0;
   localparam mode_type MODE_ON  = 3'd1;
   localparam mode_type MODE_LED = 3'd2;
   localparam mode_type MODE_NEO = 3'd3;
   localparam mode_type MODE_SEL = 3'd4;

   localparam pattern_type PAT_NONE        = 3'd0;
   localparam pattern_type PAT_LED_BLINK   = 3'd1;
   localparam pattern_type PAT_LED_ALT     = 3'd2;
   localparam pattern_type PAT_LED_SHIFT   = 3'd3;
   localparam pattern_type PAT_PIX_BLINK   = 3'd4;
   localparam pattern_type PAT_PIX_SHIFT   = 3'd5;
   localparam pattern_type PAT_PIX_BREATHE = 3'd6;

   localparam logic [7:0] LED_CMD_BLINK = 8'h01;
   localparam logic [7:0] LED_CMD_ALT   = 8'h02;
   localparam logic [7:0] LED_CMD_SHIFT = 8'h03;

   localparam logic [7:0] ADC_CMD_ON  = 8'h01;
   localparam logic [7:0] ADC_CMD_OFF = 8'h02;
   localparam logic [7:0] ADC_CMD_LED = 8'h03;
   localparam logic [7:0] ADC_CMD_NEO = 8'h04;

   localparam logic [7:0] NEO_CMD_BLINK   = 8'h10;
   localparam logic [7:0] NEO_CMD_SHIFT   = 8'h20;
   localparam logic [7:0] NEO_CMD_BREATHE = 8'h40;
   localparam logic [7:0] NEO_CMD_SELECT  = 8'h80;

   localparam logic [23:0] WORD_LED = "LED";
   localparam logic [23:0] WORD_ADC = "ADC";
   localparam logic [63:0] WORD_NEO = "NEOPIXEL";

   typedef struct packed {
      status_type  status;
      logic [7:0]  command;
      logic [7:0]  param;
      logic        has_led;
      logic        has_adc;
      logic        has_neo;
   } frame_evt_type;

endpackage

@@ hdl/framed_command_receiver_mode_control.sv @@
// ----------------------------------------------------------------------------
// framed_command_receiver_mode_control - framed command receiver, top level
// Usage:
//   req_ carries one word per handshake: a serial byte (req_cmd 0) or a
//   converter sample (req_cmd 1). rsp_ returns exactly one word for each
//   request word, in order: the echo, frame status, mode after the word,
//   any requested pattern and the LED and pixel masks.
//   rsp_valid rises once the word has passed both registers: the input
//   register takes the word at the accepting edge, and the parse and mode
//   logic load the result register when it is empty or being taken. One
//   word per cycle is sustained while rsp_ready stays high; the result
//   register frees the input side while a result waits.
//   If rsp_ready stays low, the result register holds, the input register
//   fills, and req_ready then drops until the result is taken.
//   Synchronous reset empties both registers, returns the parser to waiting
//   for a start byte, clears the name store and sets the mode to off with no
//   pixels selected.
// ----------------------------------------------------------------------------
module framed_command_receiver_mode_control #(
   parameter int NAME_MAX = fcr_pkg::NAME_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [7:0]                          req_rx_byte,
   input  logic [fcr_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_echo_valid,
   output logic [7:0]                          rsp_echo_byte,
   output logic [1:0]                          rsp_frame_status,
   output logic [2:0]                          rsp_mode,
   output logic [2:0]                          rsp_pattern_code,
   output logic [7:0]                          rsp_pattern_count,
   output logic [fcr_pkg::LED_COUNT-1:0]       rsp_led_bar,
   output logic [fcr_pkg::PIXEL_COUNT-1:0]     rsp_pixel_mask
);

   logic                              in_valid_ff, in_valid_in;
   logic                              in_cmd_ff;
   logic [7:0]                        in_byte_ff;
   logic [fcr_pkg::SAMPLE_BITS-1:0]   in_sample_ff;
   logic                              out_valid_ff, out_valid_in;
   logic                              advance;
   logic                              step;
   logic                              take;

   fcr_pkg::frame_evt_type            evt;
   fcr_pkg::mode_type                 mode;
   fcr_pkg::pattern_type              pattern_code;
   logic [7:0]                        pattern_count;
   logic [fcr_pkg::LED_COUNT-1:0]     led_bar;
   logic [fcr_pkg::PIXEL_COUNT-1:0]   pixel_mask;

   logic                              echo_valid_ff;
   logic [7:0]                        echo_byte_ff;
   fcr_pkg::status_type               status_ff;
   fcr_pkg::mode_type                 mode_ff;
   fcr_pkg::pattern_type              pattern_code_ff;
   logic [7:0]                        pattern_count_ff;
   logic [fcr_pkg::LED_COUNT-1:0]     led_bar_ff;
   logic [fcr_pkg::PIXEL_COUNT-1:0]   pixel_mask_ff;

   assign advance      = !out_valid_ff || rsp_ready;
   assign req_ready    = !in_valid_ff || advance;
   assign take         = req_valid && req_ready;
   assign step         = in_valid_ff && advance;
   assign in_valid_in  = take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   fcr_parse #(
      .NAME_MAX (NAME_MAX)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step && !in_cmd_ff),
      .rx_byte (in_byte_ff),
      .evt     (evt)
   );

   fcr_mode u_mode (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .is_sample     (in_cmd_ff),
      .sample        (in_sample_ff),
      .evt           (evt),
      .mode          (mode),
      .pattern_code  (pattern_code),
      .pattern_count (pattern_count),
      .led_bar       (led_bar),
      .pixel_mask    (pixel_mask)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff    <= req_cmd;
         in_byte_ff   <= req_rx_byte;
         in_sample_ff <= req_sample;
      end
      if (step) begin
         echo_valid_ff    <= !in_cmd_ff;
         echo_byte_ff     <= in_cmd_ff ? 8'd0 : in_byte_ff;
         status_ff        <= in_cmd_ff ? fcr_pkg::STAT_NONE : evt.status;
         mode_ff          <= mode;
         pattern_code_ff  <= pattern_code;
         pattern_count_ff <= pattern_count;
         led_bar_ff       <= led_bar;
         pixel_mask_ff    <= pixel_mask;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_echo_valid    = echo_valid_ff;
   assign rsp_echo_byte     = echo_byte_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_mode          = mode_ff;
   assign rsp_pattern_code  = pattern_code_ff;
   assign rsp_pattern_count = pattern_count_ff;
   assign rsp_led_bar       = led_bar_ff;
   assign rsp_pixel_mask    = pixel_mask_ff;

endmodule

@@ hdl/fcr_parse.sv @@
// ----------------------------------------------------------------------------
// fcr_parse - frame parser
// Tracks start/length/name/command/parameter/end and matches the name words.
// ----------------------------------------------------------------------------
module fcr_parse #(
   parameter int NAME_MAX = fcr_pkg::NAME_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output fcr_pkg::frame_evt_type evt
);

   localparam int LEN_W = $clog2(NAME_MAX + 1);
   localparam int IDX_W = $clog2(NAME_MAX);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LEN   = 3'd1;
   localparam logic [2:0] PH_NAME  = 3'd2;
   localparam logic [2:0] PH_CMD   = 3'd3;
   localparam logic [2:0] PH_PARAM = 3'd4;
   localparam logic [2:0] PH_END   = 3'd5;

   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [7:0]       command_ff, command_in;
   logic [7:0]       param_ff, param_in;
   logic [7:0]       name_ff [NAME_MAX];
   logic             clear_name;
   logic             write_name;
   logic [IDX_W-1:0] name_idx;
   logic [NAME_MAX-1:0] live;
   logic             has_led, has_adc, has_neo;
   fcr_pkg::status_type status;

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      remain_in  = remain_ff;
      command_in = command_ff;
      param_in   = param_ff;
      clear_name = 1'b0;
      write_name = 1'b0;
      status     = fcr_pkg::STAT_NONE;
      name_idx   = IDX_W'(len_ff - remain_ff);
      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == fcr_pkg::BYTE_START) begin
               clear_name = 1'b1;
               phase_in   = PH_LEN;
            end
         end
         PH_LEN: begin
            if (rx_byte < 8'd2 || {1'b0, rx_byte} > 9'(NAME_MAX + 2)) begin
               status   = fcr_pkg::STAT_BAD_LEN;
               phase_in = PH_IDLE;
            end else begin
               len_in    = LEN_W'(rx_byte - 8'd2);
               remain_in = LEN_W'(rx_byte - 8'd2);
               phase_in  = (rx_byte == 8'd2) ? PH_CMD : PH_NAME;
            end
         end
         PH_NAME: begin
            write_name = 1'b1;
            remain_in  = remain_ff - LEN_W'(1);
            if (remain_ff == LEN_W'(1)) begin
               phase_in = PH_CMD;
            end
         end
         PH_CMD: begin
            command_in = rx_byte;
            phase_in   = PH_PARAM;
         end
         PH_PARAM: begin
            param_in = rx_byte;
            phase_in = PH_END;
         end
         PH_END: begin
            if (rx_byte == fcr_pkg::BYTE_END) begin
               status     = fcr_pkg::STAT_OK;
               clear_name = 1'b1;
               len_in     = '0;
               remain_in  = '0;
               command_in = '0;
            end else begin
               status = fcr_pkg::STAT_BAD_END;
            end
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // live[i]: name position i lies inside the length and before any zero byte
   always_comb begin
      logic run;
      run = 1'b1;
      for (int i = 0; i < NAME_MAX; i++) begin
         run     = run && (LEN_W'(i) < len_ff) && (name_ff[i] != 8'd0);
         live[i] = run;
      end
   end

   always_comb begin
      has_led = 1'b0;
      has_adc = 1'b0;
      has_neo = 1'b0;
      for (int s = 0; s + 3 <= NAME_MAX; s++) begin
         if (live[s + 2] && name_ff[s] == fcr_pkg::WORD_LED[23:16]
               && name_ff[s + 1] == fcr_pkg::WORD_LED[15:8]
               && name_ff[s + 2] == fcr_pkg::WORD_LED[7:0]) begin
            has_led = 1'b1;
         end
         if (live[s + 2] && name_ff[s] == fcr_pkg::WORD_ADC[23:16]
               && name_ff[s + 1] == fcr_pkg::WORD_ADC[15:8]
               && name_ff[s + 2] == fcr_pkg::WORD_ADC[7:0]) begin
            has_adc = 1'b1;
         end
      end
      for (int s = 0; s + 8 <= NAME_MAX; s++) begin
         logic hit;
         hit = live[s + 7];
         for (int k = 0; k < 8; k++) begin
            hit = hit && (name_ff[s + k] == fcr_pkg::WORD_NEO[(7 - k) * 8 +: 8]);
         end
         if (hit) begin
            has_neo = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         len_ff     <= '0;
         remain_ff  <= '0;
         command_ff <= '0;
         param_ff   <= '0;
         for (int i = 0; i < NAME_MAX; i++) begin
            name_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         remain_ff  <= remain_in;
         command_ff <= command_in;
         param_ff   <= param_in;
         if (clear_name) begin
            for (int i = 0; i < NAME_MAX; i++) begin
               name_ff[i] <= '0;
            end
         end else if (write_name) begin
            name_ff[name_idx] <= rx_byte;
         end
      end
   end

   assign evt.status  = status;
   assign evt.command = command_ff;
   assign evt.param   = param_ff;
   assign evt.has_led = has_led;
   assign evt.has_adc = has_adc;
   assign evt.has_neo = has_neo;

endmodule

@@ hdl/fcr_mode.sv @@
// ----------------------------------------------------------------------------
// fcr_mode - mode machine and display masks
// Applies completed frames to the mode and selection, and builds the bars.
// ----------------------------------------------------------------------------
module fcr_mode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                is_sample,
   input  logic [fcr_pkg::SAMPLE_BITS-1:0]     sample,
   input  fcr_pkg::frame_evt_type              evt,
   output fcr_pkg::mode_type                   mode,
   output fcr_pkg::pattern_type                pattern_code,
   output logic [7:0]                          pattern_count,
   output logic [fcr_pkg::LED_COUNT-1:0]       led_bar,
   output logic [fcr_pkg::PIXEL_COUNT-1:0]     pixel_mask
);

   fcr_pkg::mode_type                 mode_ff, mode_in;
   logic [fcr_pkg::PIXEL_COUNT-1:0]   select_ff, select_in;
   logic [fcr_pkg::PIX_LVL_W-1:0]     sel_pos;
   logic [fcr_pkg::PIX_LVL_W-1:0]     pix_lvl;
   logic [fcr_pkg::LED_LVL_W-1:0]     led_lvl;
   logic [fcr_pkg::PIXEL_COUNT-1:0]   pix_bar;
   logic [fcr_pkg::LED_COUNT-1:0]     led_therm;

   assign sel_pos = fcr_pkg::PIX_LVL_W'(evt.param - 8'd1);
   assign pix_lvl = sample[fcr_pkg::SAMPLE_BITS-1 -: fcr_pkg::PIX_LVL_W];
   assign led_lvl = sample[fcr_pkg::SAMPLE_BITS-1 -: fcr_pkg::LED_LVL_W];

   always_comb begin
      for (int i = 0; i < fcr_pkg::PIXEL_COUNT; i++) begin
         pix_bar[i] = (fcr_pkg::PIX_LVL_W'(i) <= pix_lvl);
      end
      for (int i = 0; i < fcr_pkg::LED_COUNT; i++) begin
         led_therm[i] = (fcr_pkg::LED_LVL_W'(i) <= led_lvl);
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      select_in    = select_ff;
      pattern_code = fcr_pkg::PAT_NONE;
      if (!is_sample && evt.status == fcr_pkg::STAT_OK) begin
         if (evt.has_led) begin
            mode_in = fcr_pkg::MODE_OFF;
            case (evt.command)
               fcr_pkg::LED_CMD_BLINK: pattern_code = fcr_pkg::PAT_LED_BLINK;
               fcr_pkg::LED_CMD_ALT:   pattern_code = fcr_pkg::PAT_LED_ALT;
               fcr_pkg::LED_CMD_SHIFT: pattern_code = fcr_pkg::PAT_LED_SHIFT;
               default:                pattern_code = fcr_pkg::PAT_NONE;
            endcase
         end else if (evt.has_adc) begin
            case (evt.command)
               fcr_pkg::ADC_CMD_ON: begin
                  if (mode_ff == fcr_pkg::MODE_OFF || mode_ff == fcr_pkg::MODE_SEL) begin
                     mode_in = fcr_pkg::MODE_ON;
                  end
               end
               fcr_pkg::ADC_CMD_OFF: begin
                  mode_in = fcr_pkg::MODE_OFF;
               end
               fcr_pkg::ADC_CMD_LED: begin
                  if (mode_ff == fcr_pkg::MODE_ON || mode_ff == fcr_pkg::MODE_NEO) begin
                     mode_in = fcr_pkg::MODE_LED;
                  end
               end
               fcr_pkg::ADC_CMD_NEO: begin
                  if (mode_ff == fcr_pkg::MODE_ON || mode_ff == fcr_pkg::MODE_LED) begin
                     mode_in = fcr_pkg::MODE_NEO;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end else if (evt.has_neo) begin
            mode_in = fcr_pkg::MODE_OFF;
            case (evt.command)
               fcr_pkg::NEO_CMD_BLINK:   pattern_code = fcr_pkg::PAT_PIX_BLINK;
               fcr_pkg::NEO_CMD_SHIFT:   pattern_code = fcr_pkg::PAT_PIX_SHIFT;
               fcr_pkg::NEO_CMD_BREATHE: pattern_code = fcr_pkg::PAT_PIX_BREATHE;
               fcr_pkg::NEO_CMD_SELECT: begin
                  // partner pixel sits half a ring away: flip the top index bit
                  select_in = (fcr_pkg::PIXEL_COUNT'(1) << sel_pos)
                     | (fcr_pkg::PIXEL_COUNT'(1) << {~sel_pos[fcr_pkg::PIX_LVL_W-1],
                                                     sel_pos[fcr_pkg::PIX_LVL_W-2:0]});
                  mode_in   = fcr_pkg::MODE_SEL;
               end
               default: pattern_code = fcr_pkg::PAT_NONE;
            endcase
         end
      end
   end

   assign pattern_count = (pattern_code != fcr_pkg::PAT_NONE) ? evt.param : 8'd0;
   assign mode          = mode_in;

   always_comb begin
      led_bar    = '0;
      pixel_mask = '0;
      if (!is_sample) begin
         if (mode_in == fcr_pkg::MODE_SEL) begin
            pixel_mask = select_in;
         end
      end else begin
         case (mode_ff)
            fcr_pkg::MODE_NEO: pixel_mask = pix_bar;
            fcr_pkg::MODE_LED: led_bar    = led_therm;
            fcr_pkg::MODE_SEL: pixel_mask = select_ff;
            default: begin
               led_bar    = '0;
               pixel_mask = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= fcr_pkg::MODE_OFF;
         select_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         select_ff <= select_in;
      end
   end

endmodule
